// ===== design/assert_macros.svh =====
// Assertion macros used by the port checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/smx_pkg.sv =====
// Types, codes and decode function of the stack machine executor.
// No dependencies.
package smx_pkg;

  localparam int DEF_STACK_DEPTH = 1024;
  localparam int DEF_MEM_DEPTH   = 65536;

  localparam logic [7:0] OPC_PUSH  = 8'h01;
  localparam logic [7:0] OPC_POP   = 8'h02;
  localparam logic [7:0] OPC_ADD   = 8'h03;
  localparam logic [7:0] OPC_SUB   = 8'h04;
  localparam logic [7:0] OPC_MUL   = 8'h05;
  localparam logic [7:0] OPC_DIV   = 8'h06;
  localparam logic [7:0] OPC_STORE = 8'h07;
  localparam logic [7:0] OPC_LOAD  = 8'h08;
  localparam logic [7:0] OPC_PRINT = 8'h0D;
  localparam logic [7:0] OPC_DUP   = 8'h15;
  localparam logic [7:0] OPC_SWAP  = 8'h16;

  localparam logic [31:0] STR_MARK = 32'h0000_00FF;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_DIVZ    = 3'd3;
  localparam logic [2:0] ST_ADDR    = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic [16:0] LIMIT_RESET = 17'h1_0000;

  typedef enum logic [3:0] {
    CLS_PUSH, CLS_POP, CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV,
    CLS_STORE, CLS_LOAD, CLS_PRINT, CLS_DUP, CLS_SWAP, CLS_BAD
  } op_cls_e;

  typedef enum logic [2:0] {
    BK_CLEAR, BK_IDLE, BK_OP1, BK_OP2, BK_SWAP, BK_LOAD, BK_DIV, BK_RESULT
  } bk_state_e;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] immediate;
    logic       last_instruction;
  } in_item_t;

  typedef struct packed {
    logic               print_valid;
    logic               print_kind;
    logic signed [31:0] print_value;
    logic [2:0]         status;
    logic [10:0]        stack_depth;
    logic               program_done;
  } out_item_t;

  typedef struct packed {
    op_cls_e    cls;
    logic [7:0] imm;
    logic       last;
  } dec_item_t;

  function automatic op_cls_e classify(input logic [7:0] opc);
    op_cls_e c;
    unique case (opc)
      OPC_PUSH:  c = CLS_PUSH;
      OPC_POP:   c = CLS_POP;
      OPC_ADD:   c = CLS_ADD;
      OPC_SUB:   c = CLS_SUB;
      OPC_MUL:   c = CLS_MUL;
      OPC_DIV:   c = CLS_DIV;
      OPC_STORE: c = CLS_STORE;
      OPC_LOAD:  c = CLS_LOAD;
      OPC_PRINT: c = CLS_PRINT;
      OPC_DUP:   c = CLS_DUP;
      OPC_SWAP:  c = CLS_SWAP;
      default:   c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

// ===== design/smx_front.sv =====
// Front end: accepts instructions, decodes them and queues them for the back end.
// Depends on smx_pkg.
module smx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hold_i,
  input  logic               push_i,
  input  smx_pkg::in_item_t  item_i,
  output logic               full_o,
  output logic               deq_valid_o,
  output smx_pkg::dec_item_t deq_item_o,
  input  logic               deq_i
);
  import smx_pkg::*;

  dec_item_t  buf_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       enq;

  assign full_o      = hold_i || (cnt_q == 2'd2);
  assign enq         = push_i && !full_o;
  assign deq_valid_o = (cnt_q != 2'd0);
  assign deq_item_o  = buf_q[rptr_q];

  always_comb begin
    wptr_d = enq ? !wptr_q : wptr_q;
    rptr_d = deq_i ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(enq) - 2'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      buf_q[wptr_q] <= '{cls: classify(item_i.opcode), imm: item_i.immediate,
                         last: item_i.last_instruction};
    end
  end

endmodule

// ===== design/smx_div.sv =====
// Radix-2 restoring signed divider, one quotient bit a cycle, truncating.
// No dependencies.
module smx_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic        busy_q, fin_q;
  logic [4:0]  step_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic        neg_q;
  logic [32:0] r_sh, diff;
  logic        ge;

  always_comb begin
    r_sh = {rem_q, quo_q[31]};
    diff = r_sh - {1'b0, dvs_q};
    ge   = !diff[32];
  end

  assign done_o = fin_q;
  assign quot_o = neg_q ? (32'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      step_q <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      dvs_q <= divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      neg_q <= dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : r_sh[31:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

endmodule

// ===== design/smx_back.sv =====
// Back end: sequencer over the operand stack and data memory, with the result register.
// Depends on smx_pkg and smx_div.
module smx_back #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH,
  parameter int MEM_DEPTH   = smx_pkg::DEF_MEM_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [16:0]        limit_i,
  input  logic               q_valid_i,
  input  smx_pkg::dec_item_t q_item_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  input  logic               pop_i,
  output logic               empty_o,
  output smx_pkg::out_item_t out_item_o
);
  import smx_pkg::*;

  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int MAW = $clog2(MEM_DEPTH);

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [7:0]  dm_mem  [MEM_DEPTH];

  bk_state_e   state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_m1, cnt_m2;
  op_cls_e     cls_q, cls_d;
  logic        last_q, last_d;
  logic [31:0] top_q, top_d;
  logic [2:0]  st_q, st_d;
  logic        pv_q, pv_d, pk_q, pk_d;
  logic [31:0] val_q, val_d;
  logic [MAW-1:0] clr_q, clr_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic          stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [31:0]   stk_wdata, stk_rd_q;
  logic          dm_we;
  logic [MAW-1:0] dm_addr;
  logic [7:0]    dm_wdata, dm_rd_q;

  logic        div_start, div_done;
  logic [31:0] div_q;
  logic        full_stk, ok_rd, ok_top;
  logic [31:0] prod;

  smx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stk_rd_q),
    .divisor_i  (top_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign cnt_m1     = cnt_q - CW'(1);
  assign cnt_m2     = cnt_q - CW'(2);
  assign full_stk   = (cnt_q >= CW'(STACK_DEPTH));
  assign ok_rd      = (stk_rd_q < 32'(limit_i)) && (stk_rd_q < 32'(MEM_DEPTH));
  assign prod       = stk_rd_q * top_q;
  assign clearing_o = (state_q == BK_CLEAR);
  assign empty_o    = !out_valid_q;
  assign out_item_o = out_q;
  assign ok_top     = (stk_rd_q < 32'(limit_i)) && (stk_rd_q < 32'(MEM_DEPTH));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cls_d       = cls_q;
    last_d      = last_q;
    top_d       = top_q;
    st_d        = st_q;
    pv_d        = pv_q;
    pk_d        = pk_q;
    val_d       = val_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    stk_we      = 1'b0;
    stk_waddr   = cnt_q[SAW-1:0];
    stk_wdata   = top_q;
    stk_raddr   = cnt_m1[SAW-1:0];
    dm_we       = 1'b0;
    dm_addr     = stk_rd_q[MAW-1:0];
    dm_wdata    = top_q[7:0];
    div_start   = 1'b0;
    q_pop_o     = 1'b0;

    unique case (state_q)
      BK_CLEAR: begin
        dm_we    = 1'b1;
        dm_addr  = clr_q;
        dm_wdata = 8'd0;
        clr_d    = clr_q + MAW'(1);
        if (clr_q == MAW'(MEM_DEPTH - 1)) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cls_d   = q_item_i.cls;
          last_d  = q_item_i.last;
          st_d    = ST_OK;
          pv_d    = 1'b0;
          pk_d    = 1'b0;
          val_d   = 32'd0;
          state_d = BK_RESULT;
          unique case (q_item_i.cls)
            CLS_PUSH: begin
              if (full_stk) st_d = ST_OVER;
              else begin
                stk_we    = 1'b1;
                stk_wdata = {24'd0, q_item_i.imm};
                cnt_d     = cnt_q + CW'(1);
              end
            end
            CLS_POP: begin
              if (cnt_q == '0) st_d = ST_UNDER;
              else cnt_d = cnt_m1;
            end
            CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV, CLS_STORE: begin
              if (cnt_q < CW'(2)) begin
                st_d  = ST_UNDER;
                cnt_d = '0;
              end else state_d = BK_OP1;
            end
            CLS_LOAD, CLS_PRINT: begin
              if (cnt_q == '0) st_d = ST_UNDER;
              else state_d = BK_OP1;
            end
            CLS_DUP: begin
              if (cnt_q == '0) st_d = ST_UNDER;
              else if (full_stk) st_d = ST_OVER;
              else state_d = BK_OP1;
            end
            CLS_SWAP: begin
              if (cnt_q < CW'(2)) st_d = ST_UNDER;
              else state_d = BK_OP1;
            end
            default: st_d = ST_UNKNOWN;
          endcase
        end
      end
      BK_OP1: begin
        top_d     = stk_rd_q;
        stk_raddr = cnt_m2[SAW-1:0];
        state_d   = BK_OP2;
        priority case (cls_q)
          CLS_DUP: begin
            stk_we    = 1'b1;
            stk_wdata = stk_rd_q;
            cnt_d     = cnt_q + CW'(1);
            state_d   = BK_RESULT;
          end
          CLS_LOAD: begin
            cnt_d = cnt_m1;
            if (ok_top) state_d = BK_LOAD;
            else begin
              st_d    = ST_ADDR;
              state_d = BK_RESULT;
            end
          end
          CLS_PRINT: begin
            if (stk_rd_q == STR_MARK) begin
              if (cnt_q == CW'(1)) begin
                cnt_d   = '0;
                st_d    = ST_UNDER;
                state_d = BK_RESULT;
              end
            end else begin
              pv_d    = 1'b1;
              val_d   = stk_rd_q;
              cnt_d   = cnt_m1;
              state_d = BK_RESULT;
            end
          end
          default: state_d = BK_OP2;
        endcase
      end
      BK_OP2: begin
        state_d   = BK_RESULT;
        stk_waddr = cnt_m2[SAW-1:0];
        priority case (cls_q)
          CLS_ADD: begin
            stk_we    = 1'b1;
            stk_wdata = stk_rd_q + top_q;
            cnt_d     = cnt_m1;
          end
          CLS_SUB: begin
            stk_we    = 1'b1;
            stk_wdata = stk_rd_q - top_q;
            cnt_d     = cnt_m1;
          end
          CLS_MUL: begin
            stk_we    = 1'b1;
            stk_wdata = prod;
            cnt_d     = cnt_m1;
          end
          CLS_DIV: begin
            if (top_q == 32'd0) begin
              st_d  = ST_DIVZ;
              cnt_d = cnt_m2;
            end else begin
              div_start = 1'b1;
              state_d   = BK_DIV;
            end
          end
          CLS_STORE: begin
            cnt_d = cnt_m2;
            if (ok_rd) dm_we = 1'b1;
            else st_d = ST_ADDR;
          end
          CLS_PRINT: begin
            pv_d  = 1'b1;
            pk_d  = 1'b1;
            val_d = stk_rd_q;
            cnt_d = cnt_m2;
          end
          default: begin
            stk_we    = 1'b1;
            stk_waddr = cnt_m1[SAW-1:0];
            stk_wdata = stk_rd_q;
            state_d   = BK_SWAP;
          end
        endcase
      end
      BK_SWAP: begin
        stk_we    = 1'b1;
        stk_waddr = cnt_m2[SAW-1:0];
        stk_wdata = top_q;
        state_d   = BK_RESULT;
      end
      BK_LOAD: begin
        stk_we    = 1'b1;
        stk_wdata = {24'd0, dm_rd_q};
        cnt_d     = cnt_q + CW'(1);
        state_d   = BK_RESULT;
      end
      BK_DIV: begin
        if (div_done) begin
          stk_we    = 1'b1;
          stk_waddr = cnt_m2[SAW-1:0];
          stk_wdata = div_q;
          cnt_d     = cnt_m1;
          state_d   = BK_RESULT;
        end
      end
      BK_RESULT: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d        = 1'b1;
          out_d.print_valid  = pv_q;
          out_d.print_kind   = pk_q;
          out_d.print_value  = val_q;
          out_d.status       = st_q;
          out_d.stack_depth  = 11'(cnt_q);
          out_d.program_done = last_q;
          state_d            = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q  <= cls_d;
    last_q <= last_d;
    top_q  <= top_d;
    st_q   <= st_d;
    pv_q   <= pv_d;
    pk_q   <= pk_d;
    val_q  <= val_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dm_we) dm_mem[dm_addr] <= dm_wdata;
    dm_rd_q <= dm_mem[dm_addr];
  end

endmodule

// ===== design/stack_machine_executor.sv =====
// Top level of the stack machine executor: register port, front end and back end.
// Depends on smx_pkg, smx_front and smx_back.
//
//   port group        | dir | beat taken when
//   push/full/in_item | in  | push && !full
//   empty/pop/out_item| out | pop && !empty
//   psel..pready      | cfg | psel && penable && pwrite (pready tied high)
//
// States between idle and result: none for push, pop, unknown, and any decode under/overflow.
// Dup, number print, bad load address: OP1; add, sub, mul, store, string print: OP1, OP2;
// load: OP1, LOAD; swap: OP1, OP2, SWAP; div: OP1, OP2, DIV (zero divisor: OP1, OP2).
// After reset the data memory is zeroed one byte a cycle, with full high.
// The front queue holds two beats, so input is still taken while a result waits, until it fills.
module stack_machine_executor #(
  parameter int STACK_DEPTH = smx_pkg::DEF_STACK_DEPTH,
  parameter int MEM_DEPTH   = smx_pkg::DEF_MEM_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  smx_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output smx_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import smx_pkg::*;

  logic [16:0] limit_q;
  logic        q_valid, q_pop, clearing;
  dec_item_t   q_item;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {15'd0, limit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      limit_q <= pwdata[16:0];
    end
  end

  smx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (clearing),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .deq_valid_o (q_valid),
    .deq_item_o  (q_item),
    .deq_i       (q_pop)
  );

  smx_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_DEPTH   (MEM_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

// ===== design/smx_checker.sv =====
// Port checker for the stack machine executor, bound to the top level.
// Depends on smx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smx_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input smx_pkg::out_item_t out_item_o
);
  import smx_pkg::*;

  `ASSERT_IMPL(a_kind_needs_valid, clk_i, rst_ni, !empty && out_item_o.print_kind, out_item_o.print_valid)
  `ASSERT_IMPL(a_print_is_ok, clk_i, rst_ni, !empty && out_item_o.print_valid, out_item_o.status == ST_OK)
  `ASSERT_IMPL(a_status_known, clk_i, rst_ni, !empty, out_item_o.status <= ST_UNKNOWN)
  `ASSERT_NEXT(a_result_held, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))

endmodule

bind stack_machine_executor smx_checker u_smx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);
